// ===== hw/rtl/ile_pkg.sv =====
// Package for the indexed list engine: request and status codes, sizes,
// and the controller-to-datapath command struct. No dependencies.
package ile_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;

    localparam logic [3:0] REQ_PUSH_BACK  = 4'd0;
    localparam logic [3:0] REQ_PUSH_FRONT = 4'd1;
    localparam logic [3:0] REQ_INSERT     = 4'd2;
    localparam logic [3:0] REQ_POP_FRONT  = 4'd3;
    localparam logic [3:0] REQ_POP_BACK   = 4'd4;
    localparam logic [3:0] REQ_POP_INDEX  = 4'd5;
    localparam logic [3:0] REQ_CLEAR      = 4'd6;
    localparam logic [3:0] REQ_READ       = 4'd7;
    localparam logic [3:0] REQ_FIND       = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic             load;    // capture request
        logic             done;    // shift cells, register result
    } ile_cmd_t;

endpackage

// ===== hw/rtl/ile_ctrl.sv =====
// Controller state machine for the indexed list engine.
// Depends on ile_pkg.
module ile_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output ile_pkg::ile_cmd_t cmd
);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.done   = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg == S_EXEC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

// ===== hw/rtl/ile_dp.sv =====
// Datapath: shifting cell array, count, request decode and result registers.
// Depends on ile_pkg.
module ile_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ile_pkg::ile_cmd_t          cmd,
    input  logic [3:0]                 req_type,
    input  logic signed [31:0]         value,
    input  logic [6:0]                 position,
    output logic signed [31:0]         read_value,
    output logic                       found,
    output logic [ile_pkg::CNT_W-1:0]  count,
    output logic [1:0]                 status,
    output logic                       done
);
    localparam int N = ile_pkg::CAPACITY;
    localparam int CW = ile_pkg::CNT_W;

    logic signed [31:0] cell_reg [N];
    logic [CW-1:0]      cnt_reg;
    logic [3:0]         req_reg;
    logic signed [31:0] val_reg;
    logic [CW-1:0]      pos_reg;
    logic [1:0]         st_reg;
    logic               ins_reg, del_reg, clr_reg;
    logic [N-1:0]       le_reg, eq_reg;
    logic signed [31:0] rd_reg;

    // decode at capture
    logic [1:0]    st_c;
    logic          ins_c, del_c, clr_c;
    logic [CW-1:0] pos_c;
    logic [CW-1:0] pos_in;

    assign pos_in = position;

    always_comb
    begin
        st_c  = ile_pkg::ST_OK;
        ins_c = 1'b0;
        del_c = 1'b0;
        clr_c = 1'b0;
        pos_c = pos_in;
        case (req_type)
            ile_pkg::REQ_PUSH_BACK, ile_pkg::REQ_PUSH_FRONT, ile_pkg::REQ_INSERT:
            begin
                if (req_type == ile_pkg::REQ_PUSH_BACK)
                    pos_c = cnt_reg;
                else if (req_type == ile_pkg::REQ_PUSH_FRONT)
                    pos_c = '0;
                if (cnt_reg >= CW'(N))
                    st_c = ile_pkg::ST_FULL;
                else if (pos_c > cnt_reg)
                    st_c = ile_pkg::ST_RANGE;
                else
                    ins_c = 1'b1;
            end
            ile_pkg::REQ_POP_FRONT, ile_pkg::REQ_POP_BACK, ile_pkg::REQ_POP_INDEX:
            begin
                if (req_type == ile_pkg::REQ_POP_FRONT)
                    pos_c = '0;
                else if (req_type == ile_pkg::REQ_POP_BACK)
                    pos_c = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                    st_c = ile_pkg::ST_EMPTY;
                else if (pos_c >= cnt_reg)
                    st_c = ile_pkg::ST_RANGE;
                else
                    del_c = 1'b1;
            end
            ile_pkg::REQ_CLEAR: clr_c = 1'b1;
            ile_pkg::REQ_READ:
            begin
                if (cnt_reg == '0)
                    st_c = ile_pkg::ST_EMPTY;
                else if (pos_c >= cnt_reg)
                    st_c = ile_pkg::ST_RANGE;
            end
            default: ;
        endcase
    end

    // capture stage: decode, per-cell compares against the key, read port
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            val_reg <= value;
            pos_reg <= pos_c;
            st_reg  <= st_c;
            ins_reg <= ins_c;
            del_reg <= del_c;
            clr_reg <= clr_c;
            rd_reg  <= cell_reg[pos_c[ile_pkg::IDX_W-1:0]];
            for (int i = 0; i < N; i++)
            begin
                le_reg[i] <= (cell_reg[i] <= value);
                eq_reg[i] <= (cell_reg[i] == value);
            end
        end
    end

    // find: scan stops at the first entry above key or at the count; mask gives cells before it
    logic [N-1:0] scan_ok;
    logic         fnd;
    always_comb
    begin
        scan_ok[0] = le_reg[0] && (cnt_reg > CW'(0));
        for (int i = 1; i < N; i++)
            scan_ok[i] = scan_ok[i-1] && le_reg[i] && (cnt_reg > CW'(i));
        fnd = |(scan_ok & eq_reg);
    end

    // execute stage: shift cells
    always_ff @(posedge clk)
    begin
        if (cmd.done && ins_reg)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (CW'(i) == pos_reg)
                    cell_reg[i] <= val_reg;
                else if (i > 0 && CW'(i) > pos_reg)
                    cell_reg[i] <= cell_reg[(i > 0) ? i - 1 : 0];
            end
        end
        else if (cmd.done && del_reg)
        begin
            for (int i = 0; i < N - 1; i++)
            begin
                if (CW'(i) >= pos_reg)
                    cell_reg[i] <= cell_reg[i + 1];
            end
        end
    end

    logic [CW-1:0] cnt_new;
    always_comb
    begin
        cnt_new = cnt_reg;
        if (clr_reg)
            cnt_new = '0;
        else if (ins_reg)
            cnt_new = cnt_reg + CW'(1);
        else if (del_reg)
            cnt_new = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            done    <= 1'b0;
        end
        else
        begin
            done <= cmd.done;
            if (cmd.done)
                cnt_reg <= cnt_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.done)
        begin
            count      <= cnt_new;
            status     <= st_reg;
            found      <= (req_reg == ile_pkg::REQ_FIND) && fnd;
            read_value <= (req_reg == ile_pkg::REQ_READ && st_reg == ile_pkg::ST_OK)
                          ? rd_reg : 32'sd0;
        end
    end
endmodule

// ===== hw/rtl/indexed_list_engine.sv =====
// Top level of the indexed list engine: controller plus datapath.
// Depends on ile_pkg, ile_ctrl, ile_dp.
//
// Usage: drive req_type, value and position with start high while busy is
// low; that edge transfers the request. The list is held in 64 shifting
// cells with a 7-bit count. The start edge captures the request along with
// the key compares against every cell; the next edge shifts the cells,
// updates the count and registers the result (read_value, found, count,
// status), which is marked by done for exactly one cycle; it cannot be
// held off.
// A new request is not taken until the controller's capture/shift sequence
// is through; busy is high in the cycle after the start edge.
// Reset clears the count and the controller; cell contents are undefined
// until written, and cells beyond the count never reach the outputs.
module indexed_list_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [3:0]                req_type,
    input  logic signed [31:0]        value,
    input  logic [6:0]                position,
    output logic                      done,
    output logic signed [31:0]        read_value,
    output logic                      found,
    output logic [6:0]                count,
    output logic [1:0]                status
);
    ile_pkg::ile_cmd_t cmd;

    ile_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    ile_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req_type   (req_type),
        .value      (value),
        .position   (position),
        .read_value (read_value),
        .found      (found),
        .count      (count),
        .status     (status),
        .done       (done)
    );
endmodule
